/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the radix converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, switched off while rst_n is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same check on the usual clock and reset of this project.
`define ASSERT_DEFAULT(lbl, prop) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop)

`endif

/* design/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// i2a_pkg
// Types and constants shared by the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Conversion kinds as they arrive on the input stream.
  typedef enum logic [2:0] {
    KIND_HEX  = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_OCT  = 3'd2,
    KIND_SDEC = 3'd3,
    KIND_NONE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RADIX_HEX = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_OCT = 2'd2
  } radix_e;

  // Control part of one queued job; the magnitude travels beside it.
  typedef struct packed {
    radix_e radix;
    logic   neg;
  } job_t;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

endpackage

/* design/integer_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Streams the ASCII text of an integer in hex, octal or decimal.
// ----------------------------------------------------------------------------
// Each input item carries a value and a kind; the block emits its digits most
// significant first, one character per output item, with tlast on the final
// one. Negative signed decimal values start with '-', zero gives one '0', hex
// is lower case and unsupported kinds produce nothing. A two-entry queue sits
// between the input classifier and the converter, so up to two values can be
// taken while the converter is busy. The converter handles one value at a
// time: hex and octal values load straight into the digit register, while
// decimal first runs a binary to BCD conversion at four bits per cycle.
// The digit register then shifts out one digit at a time, dropping leading
// zeros without using the output and sending one character per cycle while
// the output is ready, after a minus sign where one is needed.
module integer_to_ascii_radix #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] value
  input  logic [7:0]  s_axis_tuser_i,   // [2:0] kind, [7:3] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] char_code
  output logic        m_axis_tlast_o    // last
);

  localparam int JOB_W = $bits(i2a_pkg::job_t);
  localparam int Q_W   = JOB_W + VALUE_BITS;

  logic                  q_full, q_push, q_pop, q_valid;
  i2a_pkg::job_t         push_job, pop_job;
  logic [VALUE_BITS-1:0] push_mag, pop_mag;
  logic [Q_W-1:0]        pop_data;

  i2a_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .kind_i    (s_axis_tuser_i[i2a_pkg::KIND_W-1:0]),
    .value_i   (s_axis_tdata_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (push_job),
    .q_mag_o   (push_mag)
  );

  i2a_fifo #(
    .WIDTH(Q_W),
    .DEPTH(2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_job, push_mag}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  assign pop_job = i2a_pkg::job_t'(pop_data[Q_W-1 -: JOB_W]);
  assign pop_mag = pop_data[VALUE_BITS-1:0];

  i2a_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (pop_job),
    .q_mag_i   (pop_mag),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

/* design/i2a_fifo.sv */
// ----------------------------------------------------------------------------
// i2a_fifo
// Short first-in first-out queue between the classifier and the converter.
// ----------------------------------------------------------------------------
module i2a_fifo #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/i2a_front.sv */
// ----------------------------------------------------------------------------
// i2a_front
// Accepts input items, decodes the conversion kind and forms the magnitude.
// ----------------------------------------------------------------------------
module i2a_front #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [i2a_pkg::KIND_W-1:0]  kind_i,
  input  logic [63:0]                 value_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output i2a_pkg::job_t               q_job_o,
  output logic [VALUE_BITS-1:0]       q_mag_o
);

  logic [VALUE_BITS-1:0] v;
  logic                  keep;

  assign v         = value_i[VALUE_BITS-1:0];
  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i && keep;

  always_comb begin
    keep          = 1'b1;
    q_job_o.radix = i2a_pkg::RADIX_DEC;
    q_job_o.neg   = 1'b0;
    q_mag_o       = v;
    unique case (i2a_pkg::kind_e'(kind_i))
      i2a_pkg::KIND_HEX:  q_job_o.radix = i2a_pkg::RADIX_HEX;
      i2a_pkg::KIND_UDEC: q_job_o.radix = i2a_pkg::RADIX_DEC;
      i2a_pkg::KIND_OCT:  q_job_o.radix = i2a_pkg::RADIX_OCT;
      i2a_pkg::KIND_SDEC: begin
        // The most negative value negates to itself, which is its magnitude.
        q_job_o.neg = v[VALUE_BITS-1];
        if (v[VALUE_BITS-1]) begin
          q_mag_o = ~v + VALUE_BITS'(1);
        end
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

/* design/i2a_back.sv */
// ----------------------------------------------------------------------------
// i2a_back
// Turns a queued magnitude into digits and streams the characters out.
// ----------------------------------------------------------------------------
module i2a_back #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  i2a_pkg::job_t               q_job_i,
  input  logic [VALUE_BITS-1:0]       q_mag_i,
  output logic                        q_pop_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [i2a_pkg::CHAR_W-1:0]  m_char_o,
  output logic                        m_last_o
);

  localparam int NDEC   = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int OCTD   = (VALUE_BITS + 2) / 3;
  localparam int HEXD   = (VALUE_BITS + 3) / 4;
  localparam int NDIG   = (NDEC > OCTD) ? NDEC : OCTD;
  localparam int DW     = NDIG * 4;
  localparam int PADW   = HEXD * 4;
  localparam int PASS_W = (HEXD > 1) ? $clog2(HEXD) : 1;
  localparam int REM_W  = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e                     state_q;
  logic                       sign_q;
  logic                       lead_q;
  logic [DW-1:0]              dig_q;
  logic [PADW-1:0]            bin_q;
  logic [PASS_W-1:0]          pass_q;
  logic [REM_W-1:0]           rem_q;
  logic                       m_valid_q;
  logic [i2a_pkg::CHAR_W-1:0] m_char_q;
  logic                       m_last_q;

  logic [DW-1:0]   magx;
  logic [DW-1:0]   fill_oct;
  logic [DW-1:0]   dd_bcd;
  logic [PADW-1:0] dd_bin;
  logic [3:0]      top_dig;
  logic            out_free;
  logic            last_dig;
  logic            emit;

  assign magx      = DW'(q_mag_i);
  assign top_dig   = dig_q[DW-1 -: 4];
  assign out_free  = !m_valid_q || m_ready_i;
  assign last_dig  = (rem_q == REM_W'(1));
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign m_valid_o = m_valid_q;
  assign m_char_o  = m_char_q;
  assign m_last_o  = m_last_q;

  // A character goes out unless a leading zero is being dropped.
  assign emit = (state_q == ST_EMIT) && out_free &&
                (sign_q || !(lead_q && (top_dig == 4'd0) && !last_dig));

  always_comb begin
    fill_oct = '0;
    for (int d = 0; d < NDIG; d++) begin
      fill_oct[4*d +: 4] = {1'b0, magx[3*d +: 3]};
    end
  end

  // Four shift-and-add-3 steps of the binary to BCD conversion per cycle.
  always_comb begin
    dd_bcd = dig_q;
    dd_bin = bin_q;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dd_bcd[4*d +: 4] >= 4'd5) begin
          dd_bcd[4*d +: 4] = dd_bcd[4*d +: 4] + 4'd3;
        end
      end
      {dd_bcd, dd_bin} = {dd_bcd, dd_bin} << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sign_q    <= 1'b0;
      lead_q    <= 1'b0;
      dig_q     <= '0;
      bin_q     <= '0;
      pass_q    <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      m_valid_q <= emit || (m_valid_q && !m_ready_i);
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            sign_q <= q_job_i.neg;
            lead_q <= 1'b1;
            rem_q  <= REM_W'(NDIG);
            case (q_job_i.radix)
              i2a_pkg::RADIX_DEC: begin
                dig_q   <= '0;
                bin_q   <= PADW'(q_mag_i);
                pass_q  <= '0;
                state_q <= ST_CONV;
              end
              i2a_pkg::RADIX_OCT: begin
                dig_q   <= fill_oct;
                state_q <= ST_EMIT;
              end
              default: begin
                dig_q   <= magx;
                state_q <= ST_EMIT;
              end
            endcase
          end
        end
        ST_CONV: begin
          dig_q  <= dd_bcd;
          bin_q  <= dd_bin;
          pass_q <= pass_q + PASS_W'(1);
          if (pass_q == PASS_W'(HEXD - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sign_q) begin
            if (out_free) begin
              m_char_q <= i2a_pkg::CHAR_MINUS;
              m_last_q <= 1'b0;
              sign_q   <= 1'b0;
            end
          end else if (lead_q && (top_dig == 4'd0) && !last_dig) begin
            // Leading zeros drop out without using the output slot.
            dig_q <= dig_q << 4;
            rem_q <= rem_q - REM_W'(1);
          end else if (out_free) begin
            m_char_q <= i2a_pkg::GLYPHS[top_dig];
            m_last_q <= last_dig;
            lead_q   <= 1'b0;
            dig_q    <= dig_q << 4;
            rem_q    <= rem_q - REM_W'(1);
            if (last_dig) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/i2a_checker.sv */
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks on the character stream of the radix converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2a_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic       is_digit, is_hex_letter, is_minus, is_zero;
  logic       out_wait, out_take;
  logic [8:0] out_word;

  assign is_digit      = (m_axis_tdata_o >= 8'h30) && (m_axis_tdata_o <= 8'h39);
  assign is_hex_letter = (m_axis_tdata_o >= 8'h61) && (m_axis_tdata_o <= 8'h66);
  assign is_minus      = (m_axis_tdata_o == i2a_pkg::CHAR_MINUS);
  assign is_zero       = (m_axis_tdata_o == 8'h30);
  assign out_wait      = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_take      = m_axis_tvalid_o && m_axis_tready_i;
  assign out_word      = {m_axis_tlast_o, m_axis_tdata_o};

  // A waiting output item keeps its character and end mark.
  `ASSERT_DEFAULT(a_out_hold, out_wait |=> m_axis_tvalid_o && $stable(out_word))

  // Only digits, lower-case hex letters and the minus sign are produced.
  `ASSERT_DEFAULT(a_char_legal, m_axis_tvalid_o |-> is_digit || is_hex_letter || is_minus)

  // The minus sign always has a magnitude after it.
  `ASSERT_DEFAULT(a_minus_not_last, m_axis_tvalid_o && is_minus |-> !m_axis_tlast_o)

  // A taken minus sign is followed by a digit, never a leading zero.
  `ASSERT_DEFAULT(a_no_minus_zero, $past(out_take && is_minus) && m_axis_tvalid_o |-> !is_zero)

endmodule

bind integer_to_ascii_radix i2a_checker u_i2a_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
